>>> rtl/core/pfbm_pkg.sv
`default_nettype none

package pfbm_pkg;

  localparam int MAX_OCTAVES = 16;
  localparam int FRAC_BITS = 16;
  localparam int CNT_W = 5;
  localparam int REG_W = 24;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_OCTAVES = 3'd0;
  localparam logic [2:0] REG_BASE_FREQ = 3'd1;
  localparam logic [2:0] REG_BASE_AMP = 3'd2;
  localparam logic [2:0] REG_LACUNARITY = 3'd3;
  localparam logic [2:0] REG_GAIN = 3'd4;

  typedef enum logic [4:0] {
    U_IDLE, U_SX, U_SY, U_SZ,
    U_T2X, U_T3X, U_FX, U_T2Y, U_T3Y, U_FY, U_T2Z, U_T3Z, U_FZ,
    U_H1, U_H2, U_H3,
    U_L00, U_L10, U_L01, U_L11, U_M0, U_M1, U_N,
    U_ACC, U_FRQ, U_AMP
  } uop_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,
    8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,
    8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,
    8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
    8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] i);
    return PERM_ROM[i];
  endfunction

  function automatic logic signed [19:0] grad(input logic [3:0] e,
                                              input logic signed [19:0] x,
                                              input logic signed [19:0] y,
                                              input logic signed [19:0] z);
    logic signed [19:0] u;
    logic signed [19:0] v;
    u = (e < 4'd8) ? x : y;
    if (e < 4'd4) begin
      v = y;
    end else if (e == 4'd12 || e == 4'd14) begin
      v = x;
    end else begin
      v = z;
    end
    return (e[0] ? -u : u) + (e[1] ? -v : v);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/perlin_fbm_noise_3d.sv
`default_nettype none

// Fractal sum of 3D improved Perlin noise over up to sixteen octaves. A point is
// taken when start is high and busy is low; the result appears on out_noise_sum and
// out_saturated for exactly one cycle with out_valid, and must be taken then. All
// arithmetic runs through one shared 33x25-bit multiplier, whose product is registered
// in prod_r; an octave is a sequence of multiplier and hash steps, followed by the
// frequency and amplitude update between octaves. out_valid rises as busy falls after
// the last octave. With zero octaves the result (zero) follows the start cycle directly.
module perlin_fbm_noise_3d (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  input  wire logic signed [31:0] in_coord_z,
  output logic                    out_valid,
  output logic signed [31:0]      out_noise_sum,
  output logic                    out_saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [pfbm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import pfbm_pkg::*;

  logic [CNT_W-1:0] octave_count_r;
  logic [REG_W-1:0] base_freq_r, base_amp_r, lac_r, gain_r;

  uop_t uop_r, uop_nxt;
  logic ph_r, ph_nxt;
  logic [CNT_W-1:0] left_r;
  logic [CNT_W-1:0] n_oct;
  logic accept, mult_op, last_oct;

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [REG_W-1:0] freq_r, amp_r;
  logic signed [31:0] sum_r;
  logic sat_r;
  logic [31:0] sx_r, sy_r, sz_r;
  logic [15:0] t2_r, t3_r;
  logic [16:0] u_r, v_r, w_r;
  logic [7:0] ha_r, hb_r, haa_r, hab_r, hba_r, hbb_r;
  logic signed [19:0] g_r [8];
  logic signed [19:0] l00_r, l10_r, l01_r, l11_r, m0_r, m1_r, nz_r;
  logic signed [57:0] prod_r;

  logic signed [32:0] op_a;
  logic signed [24:0] op_b;
  logic signed [57:0] prod_nxt;
  logic [15:0] t_sel;
  logic [22:0] q_raw;
  logic [20:0] q_cl;
  logic signed [19:0] lerp_base, lerp_res;
  logic signed [41:0] acc;
  logic signed [19:0] fx0, fx1, fy0, fy1, fz0, fz1;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= 5'd4;
      base_freq_r    <= 24'd65536;
      base_amp_r     <= 24'd65536;
      lac_r          <= 24'd131072;
      gain_r         <= 24'd32768;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_OCTAVES:    octave_count_r <= pwdata[CNT_W-1:0];
        REG_BASE_FREQ:  base_freq_r <= pwdata[REG_W-1:0];
        REG_BASE_AMP:   base_amp_r <= pwdata[REG_W-1:0];
        REG_LACUNARITY: lac_r <= pwdata[REG_W-1:0];
        REG_GAIN:       gain_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_OCTAVES:    prdata = {27'd0, octave_count_r};
      REG_BASE_FREQ:  prdata = {8'd0, base_freq_r};
      REG_BASE_AMP:   prdata = {8'd0, base_amp_r};
      REG_LACUNARITY: prdata = {8'd0, lac_r};
      REG_GAIN:       prdata = {8'd0, gain_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign n_oct = (octave_count_r > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
                                                         : octave_count_r;
  assign busy = (uop_r != U_IDLE);
  assign accept = start && !busy;
  assign mult_op = !(uop_r == U_IDLE || uop_r == U_H1 || uop_r == U_H2 || uop_r == U_H3);
  assign last_oct = (left_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uop_r <= U_IDLE;
      ph_r  <= 1'b0;
    end else begin
      uop_r <= uop_nxt;
      ph_r  <= ph_nxt;
    end
  end

  always_comb begin
    uop_nxt = uop_r;
    ph_nxt = 1'b0;
    unique case (uop_r)
      U_IDLE: begin
        if (accept && n_oct != '0) begin
          uop_nxt = U_SX;
        end
      end
      U_ACC: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          uop_nxt = last_oct ? U_IDLE : U_FRQ;
        end
      end
      U_AMP: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          uop_nxt = U_SX;
        end
      end
      default: begin
        if (mult_op && !ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          uop_nxt = uop_t'(uop_r + 5'd1);
        end
      end
    endcase
  end

  always_comb begin
    unique case (uop_r)
      U_T2Y, U_T3Y, U_FY: t_sel = sy_r[15:0];
      U_T2Z, U_T3Z, U_FZ: t_sel = sz_r[15:0];
      default:            t_sel = sx_r[15:0];
    endcase
    q_raw = 23'd655360 + {5'd0, t2_r, 2'd0} + {6'd0, t2_r, 1'b0}
            - ({3'd0, t_sel, 4'd0} - {7'd0, t_sel});
    q_cl = q_raw[22] ? 21'd0 : q_raw[20:0];
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    lerp_base = l00_r;
    case (uop_r)
      U_SX: begin op_a = 33'(cx_r); op_b = {1'b0, freq_r}; end
      U_SY: begin op_a = 33'(cy_r); op_b = {1'b0, freq_r}; end
      U_SZ: begin op_a = 33'(cz_r); op_b = {1'b0, freq_r}; end
      U_T2X, U_T2Y, U_T2Z: begin
        op_a = {17'd0, t_sel}; op_b = {9'd0, t_sel};
      end
      U_T3X, U_T3Y, U_T3Z: begin
        op_a = {17'd0, t2_r}; op_b = {9'd0, t_sel};
      end
      U_FX, U_FY, U_FZ: begin
        op_a = {17'd0, t3_r}; op_b = {4'd0, q_cl};
      end
      U_L00: begin
        op_a = 33'(g_r[1]) - 33'(g_r[0]); op_b = {8'd0, u_r}; lerp_base = g_r[0];
      end
      U_L10: begin
        op_a = 33'(g_r[3]) - 33'(g_r[2]); op_b = {8'd0, u_r}; lerp_base = g_r[2];
      end
      U_L01: begin
        op_a = 33'(g_r[5]) - 33'(g_r[4]); op_b = {8'd0, u_r}; lerp_base = g_r[4];
      end
      U_L11: begin
        op_a = 33'(g_r[7]) - 33'(g_r[6]); op_b = {8'd0, u_r}; lerp_base = g_r[6];
      end
      U_M0: begin
        op_a = 33'(l10_r) - 33'(l00_r); op_b = {8'd0, v_r}; lerp_base = l00_r;
      end
      U_M1: begin
        op_a = 33'(l11_r) - 33'(l01_r); op_b = {8'd0, v_r}; lerp_base = l01_r;
      end
      U_N: begin
        op_a = 33'(m1_r) - 33'(m0_r); op_b = {8'd0, w_r}; lerp_base = m0_r;
      end
      U_ACC: begin op_a = 33'(nz_r); op_b = {1'b0, amp_r}; end
      U_FRQ: begin op_a = {9'd0, freq_r}; op_b = {1'b0, lac_r}; end
      U_AMP: begin op_a = {9'd0, amp_r}; op_b = {1'b0, gain_r}; end
      default: ;
    endcase
  end

  assign prod_nxt = op_a * op_b;
  assign lerp_res = lerp_base + prod_r[35:16];
  assign acc = 42'(sum_r) + prod_r[57:16];

  assign fx0 = {4'd0, sx_r[15:0]};
  assign fy0 = {4'd0, sy_r[15:0]};
  assign fz0 = {4'd0, sz_r[15:0]};
  assign fx1 = fx0 - 20'sd65536;
  assign fy1 = fy0 - 20'sd65536;
  assign fz1 = fz0 - 20'sd65536;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (accept) begin
      cx_r   <= in_coord_x;
      cy_r   <= in_coord_y;
      cz_r   <= in_coord_z;
      freq_r <= base_freq_r;
      amp_r  <= base_amp_r;
      left_r <= n_oct;
    end
    if (ph_r) begin
      case (uop_r)
        U_SX: sx_r <= prod_r[47:16];
        U_SY: sy_r <= prod_r[47:16];
        U_SZ: sz_r <= prod_r[47:16];
        U_T2X, U_T2Y, U_T2Z: t2_r <= prod_r[31:16];
        U_T3X, U_T3Y, U_T3Z: t3_r <= prod_r[31:16];
        U_FX: u_r <= prod_r[32:16];
        U_FY: v_r <= prod_r[32:16];
        U_FZ: w_r <= prod_r[32:16];
        U_L00: l00_r <= lerp_res;
        U_L10: l10_r <= lerp_res;
        U_L01: l01_r <= lerp_res;
        U_L11: l11_r <= lerp_res;
        U_M0: m0_r <= lerp_res;
        U_M1: m1_r <= lerp_res;
        U_N: nz_r <= lerp_res;
        U_FRQ: freq_r <= (prod_r[57:40] != '0) ? {REG_W{1'b1}} : prod_r[39:16];
        U_AMP: begin
          amp_r  <= (prod_r[57:40] != '0) ? {REG_W{1'b1}} : prod_r[39:16];
          left_r <= left_r - CNT_W'(1);
        end
        default: ;
      endcase
    end else begin
      case (uop_r)
        U_H1: begin
          ha_r <= perm(sx_r[23:16]) + sy_r[23:16];
          hb_r <= perm(sx_r[23:16] + 8'd1) + sy_r[23:16];
        end
        U_H2: begin
          haa_r <= perm(ha_r) + sz_r[23:16];
          hab_r <= perm(ha_r + 8'd1) + sz_r[23:16];
          hba_r <= perm(hb_r) + sz_r[23:16];
          hbb_r <= perm(hb_r + 8'd1) + sz_r[23:16];
        end
        U_H3: begin
          g_r[0] <= grad(4'(perm(haa_r)), fx0, fy0, fz0);
          g_r[1] <= grad(4'(perm(hba_r)), fx1, fy0, fz0);
          g_r[2] <= grad(4'(perm(hab_r)), fx0, fy1, fz0);
          g_r[3] <= grad(4'(perm(hbb_r)), fx1, fy1, fz0);
          g_r[4] <= grad(4'(perm(haa_r + 8'd1)), fx0, fy0, fz1);
          g_r[5] <= grad(4'(perm(hba_r + 8'd1)), fx1, fy0, fz1);
          g_r[6] <= grad(4'(perm(hab_r + 8'd1)), fx0, fy1, fz1);
          g_r[7] <= grad(4'(perm(hbb_r + 8'd1)), fx1, fy1, fz1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      sat_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (accept) begin
        sum_r <= '0;
        sat_r <= 1'b0;
        if (n_oct == '0) begin
          out_valid     <= 1'b1;
          out_noise_sum <= '0;
          out_saturated <= 1'b0;
        end
      end else if (ph_r && uop_r == U_ACC) begin
        if (acc > 42'sd2147483647) begin
          sum_r <= 32'sh7FFFFFFF;
          sat_r <= 1'b1;
        end else if (acc < -42'sd2147483648) begin
          sum_r <= 32'sh80000000;
          sat_r <= 1'b1;
        end else begin
          sum_r <= acc[31:0];
        end
        if (last_oct) begin
          out_valid <= 1'b1;
          if (acc > 42'sd2147483647) begin
            out_noise_sum <= 32'sh7FFFFFFF;
            out_saturated <= 1'b1;
          end else if (acc < -42'sd2147483648) begin
            out_noise_sum <= 32'sh80000000;
            out_saturated <= 1'b1;
          end else begin
            out_noise_sum <= acc[31:0];
            out_saturated <= sat_r;
          end
        end
      end else if (ph_r && uop_r == U_FRQ && prod_r[57:40] != '0) begin
        sat_r <= 1'b1;
      end
    end
  end

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result transfer while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && n_oct != '0) |=> busy) else $error("accepted point did not start");
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !ph_r) else $error("multiplier phase set while idle");
  a_left_nz: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> left_r != '0) else $error("octave counter ran out while busy");

endmodule

`default_nettype wire

>>> dv/perlin_fbm_noise_3d_tb.sv
`default_nettype none

module perlin_fbm_noise_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfbm_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam longint ONE = 65536;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 drain;
  } point_t;

  typedef struct {
    logic signed [31:0] noise_sum;
    logic               saturated;
  } fbm_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic signed [31:0] in_coord_z = '0;
  logic out_valid;
  logic signed [31:0] out_noise_sum;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  point_t point_q[$];
  fbm_t   fbm_q[$];
  point_t next_pt;
  fbm_t   got;
  logic   take;
  int     idle_pct = 0;
  int     errors = 0;
  longint cycles = 0;

  logic [4:0]  octaves_m = 5'd4;
  logic [23:0] freq_m = 24'd65536;
  logic [23:0] amp_m = 24'd65536;
  logic [23:0] lac_m = 24'd131072;
  logic [23:0] gain_m = 24'd32768;

  perlin_fbm_noise_3d dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_noise_sum(out_noise_sum), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint lattice_hash(longint i);
    return longint'(PERM_ROM[i[7:0]]);
  endfunction

  function automatic longint smoothstep5(longint t);
    longint t2, t3, q;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    q = 10 * ONE + 6 * t2 - 15 * t;
    if (q < 0) q = 0;
    return (t3 * q) >> 16;
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic longint edge_dot(longint h, longint x, longint y, longint z);
    longint e, u, v;
    e = h & 15;
    u = (e < 8) ? x : y;
    v = (e < 4) ? y : ((e == 12 || e == 14) ? x : z);
    return ((e & 1) ? -u : u) + ((e & 2) ? -v : v);
  endfunction

  function automatic logic [31:0] scaled(logic signed [31:0] c, logic [23:0] f);
    longint p;
    p = longint'(c) * longint'({1'b0, f});
    return p[47:16];
  endfunction

  function automatic longint perlin3(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    longint cx, cy, cz, x, y, z, u, v, w, x1, y1, z1;
    longint ha, hb, haa, hab, hba, hbb, l00, l10, l01, l11;
    cx = sx[23:16]; cy = sy[23:16]; cz = sz[23:16];
    x = sx[15:0]; y = sy[15:0]; z = sz[15:0];
    u = smoothstep5(x); v = smoothstep5(y); w = smoothstep5(z);
    ha = lattice_hash(cx) + cy;
    hb = lattice_hash(cx + 1) + cy;
    haa = lattice_hash(ha) + cz; hab = lattice_hash(ha + 1) + cz;
    hba = lattice_hash(hb) + cz; hbb = lattice_hash(hb + 1) + cz;
    x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
    l00 = blend(edge_dot(lattice_hash(haa), x, y, z),
                edge_dot(lattice_hash(hba), x1, y, z), u);
    l10 = blend(edge_dot(lattice_hash(hab), x, y1, z),
                edge_dot(lattice_hash(hbb), x1, y1, z), u);
    l01 = blend(edge_dot(lattice_hash(haa + 1), x, y, z1),
                edge_dot(lattice_hash(hba + 1), x1, y, z1), u);
    l11 = blend(edge_dot(lattice_hash(hab + 1), x, y1, z1),
                edge_dot(lattice_hash(hbb + 1), x1, y1, z1), u);
    return blend(blend(l00, l10, v), blend(l01, l11, v), w);
  endfunction

  function automatic fbm_t fbm_sum(point_t p);
    fbm_t r;
    longint n, freq, amp, sum, nz;
    bit sat;
    n = (octaves_m > MAX_OCTAVES) ? MAX_OCTAVES : octaves_m;
    freq = freq_m; amp = amp_m; sum = 0; sat = 0;
    for (longint i = 0; i < n; i++) begin
      nz = perlin3(scaled(p.x, freq[23:0]), scaled(p.y, freq[23:0]), scaled(p.z, freq[23:0]));
      sum += (amp * nz) >>> 16;
      if (sum > 64'sd2147483647) begin sum = 64'sd2147483647; sat = 1; end
      if (sum < -64'sd2147483648) begin sum = -64'sd2147483648; sat = 1; end
      if (i + 1 < n) begin
        freq = (freq * longint'(lac_m)) >> 16;
        if (freq > 24'hFFFFFF) begin freq = 24'hFFFFFF; sat = 1; end
        amp = (amp * longint'(gain_m)) >> 16;
        if (amp > 24'hFFFFFF) amp = 24'hFFFFFF;
      end
    end
    r.noise_sum = sum[31:0];
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        next_pt.x = in_coord_x; next_pt.y = in_coord_y; next_pt.z = in_coord_z;
        fbm_q.push_back(fbm_sum(next_pt));
      end
      if (!start || take) begin
        if (point_q.size() > 0 && (!point_q[0].drain || (fbm_q.size() == 0 && !take))
            && $urandom_range(99) >= idle_pct) begin
          next_pt = point_q.pop_front();
          in_coord_x <= next_pt.x;
          in_coord_y <= next_pt.y;
          in_coord_z <= next_pt.z;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (fbm_q.size() == 0) begin
        $error("unexpected transfer: noise_sum %0d saturated %0b", out_noise_sum,
               out_saturated);
        errors++;
      end else begin
        got = fbm_q.pop_front();
        if (out_noise_sum !== got.noise_sum) begin
          $error("noise_sum expected %0d actual %0d", got.noise_sum, out_noise_sum);
          errors++;
        end
        if (out_saturated !== got.saturated) begin
          $error("saturated expected %0b actual %0b", got.saturated, out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_OCTAVES:    octaves_m = value[4:0];
      REG_BASE_FREQ:  freq_m = value[23:0];
      REG_BASE_AMP:   amp_m = value[23:0];
      REG_LACUNARITY: lac_m = value[23:0];
      REG_GAIN:       gain_m = value[23:0];
      default: ;
    endcase
  endtask

  task automatic set_params(logic [31:0] oct, logic [31:0] f, logic [31:0] a,
                            logic [31:0] l, logic [31:0] g);
    reg_write(REG_OCTAVES, oct);
    reg_write(REG_BASE_FREQ, f);
    reg_write(REG_BASE_AMP, a);
    reg_write(REG_LACUNARITY, l);
    reg_write(REG_GAIN, g);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit drain);
    point_t p;
    p.x = x; p.y = y; p.z = z; p.drain = drain;
    point_q.push_back(p);
  endtask

  task automatic drain_all();
    while (point_q.size() > 0 || start || fbm_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {{12{1'($urandom_range(1))}}, 4'($urandom), 16'($urandom)};
      2: return {16'($urandom), ($urandom_range(1) ? 16'h0000 : 16'hFFFF)};
      default: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 24'hFFFFFF;
      2: return 0;
      default: return $urandom_range(24'h3FFFF);
    endcase
  endfunction

  initial begin
    logic [31:0] oct;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 6;

    add_point(0, 0, 0, 0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    add_point(32'h80000000, 32'h80000000, 32'h80000000, 0);
    add_point(32'h0000FFFF, 32'h00008000, 32'h00000001, 0);
    add_point(32'hFFFF0000, 32'h00010000, 32'hFFFFFFFF, 0);
    add_point(32'h00FF8000, 32'h01004000, 32'hFF00C000, 0);
    add_point(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 0);
    drain_all();

    set_params(0, 65536, 65536, 131072, 32768);
    add_point(32'h00018000, 32'h00028000, 32'h00038000, 0);
    add_point(32'h7FFFFFFF, 32'h80000000, 32'h00000000, 0);
    drain_all();

    set_params(32'hFFFFFFFF, 32'hFF010000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    reg_write(3'd5, 32'h1);
    reg_write(3'd7, 32'h0);
    add_point(32'h00058000, 32'h00024000, 32'h0003C000, 0);
    add_point(32'h80000000, 32'h7FFFFFFF, 32'h00010000, 0);
    drain_all();

    set_params(MAX_OCTAVES, 0, 24'hFFFFFF, 24'hFFFFFF, 0);
    add_point(32'h00018000, 32'h00028000, 32'h00038000, 0);
    add_point(32'h0000C000, 32'h00004000, 32'h00002000, 0);
    drain_all();

    set_params(3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h010000);
    add_point(32'h00013333, 32'h00027777, 32'hFFFC4444, 0);
    add_point(32'hDEADBEEF, 32'h01234567, 32'h76543210, 0);
    drain_all();

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 6 : ((ph < 8) ? 49 : 0);
      case ($urandom_range(19))
        0, 1, 2:  oct = MAX_OCTAVES;
        3:        oct = $urandom;
        4, 5:     oct = $urandom_range(MAX_OCTAVES);
        default:  oct = $urandom_range(4, 1);
      endcase
      set_params(oct, rand_scale(), rand_scale(), rand_scale(), rand_scale());
      for (int i = 0; i < 165; i++) begin
        add_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(99) < 3);
      end
      drain_all();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> perlin_fbm_noise_3d.f
rtl/core/pfbm_pkg.sv
rtl/core/perlin_fbm_noise_3d.sv
dv/perlin_fbm_noise_3d_tb.sv
